>>> hdl/ri2a_pkg.sv
// ri2a_pkg: widths, character codes, sequencer states and the digit glyph function
// for the radix integer-to-ascii converter. No dependencies.
package ri2a_pkg;

  localparam int WORD_W      = 32;
  localparam int BASE_W      = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int MAX_DIGITS_DEF = 32;

  // quotient bits retired per divider cycle
  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = WORD_W / DIV_BITS;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_BIG_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } state_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (dw < DIGIT_TEN) begin
      return CHAR_ZERO + dw;
    end else begin
      return CHAR_BIG_A + (dw - DIGIT_TEN);
    end
  endfunction

endpackage

>>> hdl/ri2a_ram.sv
// ri2a_ram: generic single-write, single-read ram with registered read data.
// Depends on nothing.
module ri2a_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/ri2a_div.sv
// ri2a_div: iterative divider of a 32-bit word by a small base, DIV_BITS quotient
// bits per cycle. Depends on ri2a_pkg.
module ri2a_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ri2a_pkg::WORD_W-1:0]  dividend,
  input  logic [ri2a_pkg::BASE_W-1:0]  divisor,
  output logic                         done,
  output logic [ri2a_pkg::WORD_W-1:0]  quotient,
  output logic [ri2a_pkg::DIGIT_W-1:0] remainder
);
  import ri2a_pkg::*;

  localparam int STEP_CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [STEP_CW-1:0] STEP_LAST = STEP_CW'(DIV_STEPS - 1);

  logic [WORD_W-1:0]  quo_r, quo_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [BASE_W-1:0]  div_r;
  logic [STEP_CW-1:0] cnt_r;
  logic               run_r, done_r;

  // one chunk of restoring long division; remainder stays below the base
  always_comb begin
    logic [DIGIT_W:0]   tmp;
    logic [DIGIT_W-1:0] rem;
    logic [WORD_W-1:0]  quo;
    rem = rem_r;
    quo = quo_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      tmp = {rem, quo[WORD_W-1]};
      quo = {quo[WORD_W-2:0], 1'b0};
      if (tmp >= {1'b0, div_r}) begin
        tmp    = tmp - {1'b0, div_r};
        quo[0] = 1'b1;
      end
      rem = tmp[DIGIT_W-1:0];
    end
    rem_nxt = rem;
    quo_nxt = quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r  <= cnt_r + 1'b1;
      run_r  <= (cnt_r != STEP_LAST);
      done_r <= (cnt_r == STEP_LAST);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> hdl/radix_integer_to_ascii.sv
// radix_integer_to_ascii: top level, sequencer around the shared divider and the digit ram.
// Depends on ri2a_pkg, ri2a_div and ri2a_ram.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  input    | in_value                                | start high while busy low
//  result   | out_character, out_last_char            | out_valid strobe, one cycle
//  config   | cfg_output_base                         | cfg_valid and cfg_ready
//
// each digit is one run of the shared divider; digits go least significant first
// into the digit ram. A sign step follows, then each character takes a ram read
// and then an output step, most significant digit first.
// busy is high throughout a conversion.
// reset is synchronous and returns the sequencer to idle with base ten.
// results cannot be held off: one strobe per character, never stalled.
module radix_integer_to_ascii #(
  parameter int MAX_DIGITS = ri2a_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ri2a_pkg::WORD_W-1:0]  in_value,
  output logic                         out_valid,
  output logic [ri2a_pkg::CHAR_W-1:0]  out_character,
  output logic                         out_last_char,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ri2a_pkg::BASE_W-1:0]  cfg_output_base
);
  import ri2a_pkg::*;

  localparam int AW  = $clog2(MAX_DIGITS);
  localparam int CW  = $clog2(MAX_DIGITS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

  state_t state_r, state_nxt;

  logic [BASE_W-1:0]  base_r;
  logic [BASE_W-1:0]  base_eff;
  logic               neg_r, neg_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_neg;
  logic [WORD_W-1:0]  in_mag;

  logic               div_start;
  logic [WORD_W-1:0]  div_dividend;
  logic               div_done;
  logic [WORD_W-1:0]  div_quo;
  logic [DIGIT_W-1:0] div_rem;

  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [DIGIT_W-1:0] ram_rd_data;

  always_comb begin
    if (base_r < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (base_r > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = base_r;
    end
  end

  // only base ten reads the word as two's complement
  assign in_neg = (base_eff == BASE_DEC) && in_value[WORD_W-1];
  assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_output_base;
    end
  end

  ri2a_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ri2a_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (n_r[AW-1:0]),
    .wr_data (div_rem),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      neg_r       <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      neg_r       <= neg_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    div_start     = 1'b0;
    div_dividend  = div_quo;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt      = in_neg;
          n_nxt        = '0;
          div_start    = 1'b1;
          div_dividend = in_mag;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ram_wr_en = 1'b1;
          n_nxt     = n_r + 1'b1;
          idx_nxt   = n_r[AW-1:0];
          if ((div_quo != '0) && (n_nxt < CNT_MAX)) begin
            div_start = 1'b1;
          end else begin
            state_nxt = ST_SIGN;
          end
        end
      end
      ST_SIGN: begin
        if (neg_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
        end
        state_nxt = ST_READ;
      end
      ST_READ: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = glyph(ram_rd_data);
        out_last_nxt  = (idx_r == '0);
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

endmodule

>>> hdl/ri2a_checker.sv
// ri2a_checker: port-level checks on the converter's command and result timing,
// bound to radix_integer_to_ascii. Depends on ri2a_pkg.
module ri2a_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [ri2a_pkg::WORD_W-1:0]  in_value,
  input logic                         out_valid,
  input logic [ri2a_pkg::CHAR_W-1:0]  out_character,
  input logic                         out_last_char,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [ri2a_pkg::BASE_W-1:0]  cfg_output_base
);
  import ri2a_pkg::*;

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but busy not raised");

  // every character before the last one comes while still busy
  a_mid_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |-> busy)
    else $error("non-final character outside an item");

  // the item ends with its last character
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_last_char)
    else $error("busy dropped without a final character");

  // nothing follows a final character right away
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |=> !out_valid && !$isunknown(out_character))
    else $error("character right after a final character");

  // accepted items and base writes carry known data
  a_known_data: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) || (cfg_valid && cfg_ready) |->
      !$isunknown({in_value, cfg_output_base}))
    else $error("unknown data on an accepted item or base write");

endmodule

bind radix_integer_to_ascii ri2a_checker u_ri2a_checker (.*);
